// ===== sv/tagrd_pkg.sv =====
// Shared types, constants and helper functions of the tag run detector.
package tagrd_pkg;

    localparam int COUNT_BITS = 32;

    localparam logic [20:0] TAG_FIRST  = 21'h0E0000;
    localparam logic [20:0] TAG_LAST   = 21'h0E007F;
    localparam logic [20:0] CANCEL_TAG = 21'h0E007F;
    localparam logic [20:0] BLACK_FLAG = 21'h01F3F4;
    localparam logic [6:0]  PRINT_LOW  = 7'h20;
    localparam logic [6:0]  PRINT_HIGH = 7'h7E;

    localparam logic [1:0] KIND_FINDING = 2'd0;
    localparam logic [1:0] KIND_RUN     = 2'd1;
    localparam logic [1:0] KIND_TOTALS  = 2'd2;

    localparam int RES_SLOTS = 3;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [31:0] byte_offset;
        logic        end_of_stream;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] tag_code;
        logic [31:0] where_at;
        logic [6:0]  mirrored_ascii;
        logic [31:0] run_length;
        logic        is_flag;
        logic [31:0] total_tags;
        logic [31:0] total_flag;
        logic [31:0] total_hidden;
    } result_t;

    function automatic count_t sat_add(input count_t a, input count_t b);
        logic [COUNT_BITS:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            sat_add = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
        end
    endfunction

    function automatic logic [31:0] clamp32(input count_t v);
        logic [63:0] w;
        begin
            w = 64'(v);
            clamp32 = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
        end
    endfunction

endpackage

// ===== sv/tagrd_core.sv =====
// Detector state and the combinational result list of the held codepoint.
module tagrd_core
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tagrd_pkg::item_t        item,
    input  logic                    consume,
    output tagrd_pkg::result_t      results [tagrd_pkg::RES_SLOTS],
    output logic [2:0]              present
);

    logic              run_open_reg, run_open_next;
    logic              prev_black_reg, prev_black_next;
    logic              after_flag_reg, after_flag_next;
    logic              last_cancel_reg, last_cancel_next;
    logic [31:0]       run_start_reg, run_start_next;
    tagrd_pkg::count_t run_count_reg, run_count_next;
    tagrd_pkg::count_t tags_reg, tags_next;
    tagrd_pkg::count_t flag_reg, flag_next;
    tagrd_pkg::count_t hidden_reg, hidden_next;

    logic              is_tag;
    logic              close_run;
    logic [31:0]       start1;
    tagrd_pkg::count_t count1;
    tagrd_pkg::count_t tags1;
    logic              after1;
    logic              cancel1;
    logic [31:0]       rec_start;
    tagrd_pkg::count_t rec_count;
    logic              rec_flag;
    tagrd_pkg::count_t flag2;
    tagrd_pkg::count_t hidden2;
    logic [6:0]        mirror;

    always_comb
    begin
        is_tag  = (item.code_point >= tagrd_pkg::TAG_FIRST) &&
                  (item.code_point <= tagrd_pkg::TAG_LAST);
        start1  = run_open_reg ? run_start_reg : item.byte_offset;
        count1  = tagrd_pkg::sat_add(run_open_reg ? run_count_reg : '0,
                                     tagrd_pkg::count_t'(1));
        tags1   = is_tag ? tagrd_pkg::sat_add(tags_reg, tagrd_pkg::count_t'(1)) : tags_reg;
        after1  = run_open_reg ? after_flag_reg : prev_black_reg;
        cancel1 = item.code_point == tagrd_pkg::CANCEL_TAG;

        close_run = is_tag ? item.end_of_stream : run_open_reg;
        rec_start = is_tag ? start1 : run_start_reg;
        rec_count = is_tag ? count1 : run_count_reg;
        rec_flag  = is_tag ? (after1 && cancel1) : (after_flag_reg && last_cancel_reg);

        flag2   = (close_run && rec_flag) ? tagrd_pkg::sat_add(flag_reg, rec_count) : flag_reg;
        hidden2 = (close_run && !rec_flag) ?
                  tagrd_pkg::sat_add(hidden_reg, rec_count) : hidden_reg;

        mirror = item.code_point[6:0];
        if ((mirror < tagrd_pkg::PRINT_LOW) || (mirror > tagrd_pkg::PRINT_HIGH))
        begin
            mirror = '0;
        end

        present = {item.end_of_stream, close_run, is_tag};

        results[0]                = '0;
        results[0].kind           = tagrd_pkg::KIND_FINDING;
        results[0].tag_code       = item.code_point;
        results[0].where_at       = item.byte_offset;
        results[0].mirrored_ascii = mirror;

        results[1]            = '0;
        results[1].kind       = tagrd_pkg::KIND_RUN;
        results[1].where_at   = rec_start;
        results[1].run_length = tagrd_pkg::clamp32(rec_count);
        results[1].is_flag    = rec_flag;

        results[2]              = '0;
        results[2].kind         = tagrd_pkg::KIND_TOTALS;
        results[2].total_tags   = tagrd_pkg::clamp32(tags1);
        results[2].total_flag   = tagrd_pkg::clamp32(flag2);
        results[2].total_hidden = tagrd_pkg::clamp32(hidden2);
    end

    always_comb
    begin
        run_open_next    = run_open_reg;
        prev_black_next  = prev_black_reg;
        after_flag_next  = after_flag_reg;
        last_cancel_next = last_cancel_reg;
        run_start_next   = run_start_reg;
        run_count_next   = run_count_reg;
        tags_next        = tags_reg;
        flag_next        = flag_reg;
        hidden_next      = hidden_reg;
        if (consume)
        begin
            if (item.end_of_stream)
            begin
                run_open_next    = 1'b0;
                prev_black_next  = 1'b0;
                after_flag_next  = 1'b0;
                last_cancel_next = 1'b0;
                run_start_next   = '0;
                run_count_next   = '0;
                tags_next        = '0;
                flag_next        = '0;
                hidden_next      = '0;
            end
            else
            begin
                prev_black_next = item.code_point == tagrd_pkg::BLACK_FLAG;
                tags_next       = tags1;
                flag_next       = flag2;
                hidden_next     = hidden2;
                if (is_tag)
                begin
                    run_open_next    = 1'b1;
                    after_flag_next  = after1;
                    last_cancel_next = cancel1;
                    run_start_next   = start1;
                    run_count_next   = count1;
                end
                else
                begin
                    run_open_next    = 1'b0;
                    after_flag_next  = 1'b0;
                    last_cancel_next = 1'b0;
                    run_start_next   = '0;
                    run_count_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg    <= 1'b0;
            prev_black_reg  <= 1'b0;
            after_flag_reg  <= 1'b0;
            last_cancel_reg <= 1'b0;
            run_start_reg   <= '0;
            run_count_reg   <= '0;
            tags_reg        <= '0;
            flag_reg        <= '0;
            hidden_reg      <= '0;
        end
        else
        begin
            run_open_reg    <= run_open_next;
            prev_black_reg  <= prev_black_next;
            after_flag_reg  <= after_flag_next;
            last_cancel_reg <= last_cancel_next;
            run_start_reg   <= run_start_next;
            run_count_reg   <= run_count_next;
            tags_reg        <= tags_next;
            flag_reg        <= flag_next;
            hidden_reg      <= hidden_next;
        end
    end

endmodule

// ===== sv/tagrd_seq.sv =====
// Steps through the present results of the held codepoint into the output register.
module tagrd_seq
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  tagrd_pkg::result_t      results [tagrd_pkg::RES_SLOTS],
    input  logic [2:0]              present,
    output logic                    consume,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output tagrd_pkg::result_t      m_result,
    output logic                    m_last
);

    logic [1:0]         pos_reg, pos_next;
    logic               out_valid_reg, out_valid_next;
    tagrd_pkg::result_t out_reg;
    logic               last_reg;

    logic [2:0] window;
    logic [2:0] avail;
    logic [1:0] idx;
    logic [2:0] pick;
    logic       is_last;
    logic       load_ok;
    logic       load;

    always_comb
    begin
        unique case (pos_reg)
            2'd0:    window = 3'b111;
            2'd1:    window = 3'b110;
            2'd2:    window = 3'b100;
            default: window = 3'b000;
        endcase
        avail = present & window;
        priority if (avail[0])
        begin
            idx  = 2'd0;
            pick = 3'b001;
        end
        else if (avail[1])
        begin
            idx  = 2'd1;
            pick = 3'b010;
        end
        else
        begin
            idx  = 2'd2;
            pick = 3'b100;
        end
        is_last = (avail & ~pick) == 3'b000;
        load_ok = !out_valid_reg || m_tready;
        load    = item_valid && load_ok && (avail != 3'b000);
        consume = item_valid && ((avail == 3'b000) || (load && is_last));

        pos_next = pos_reg;
        if (consume)
        begin
            pos_next = 2'd0;
        end
        else if (load)
        begin
            pos_next = idx + 2'd1;
        end

        out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg  <= results[idx];
            last_reg <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;
    assign m_last   = last_reg;

endmodule

// ===== sv/unicode_tag_run_detector.sv =====
// Top level of the tag run detector: input register, detector core and output sequencer.
//
// Slave stream: one decoded codepoint per beat; s_tdata carries code_point and byte_offset,
// s_tlast marks the final codepoint of the text.
// Master stream: one result per beat; m_tuser carries the kind (finding, run record,
// totals), m_tdata the result fields, m_tlast marks the last result of one codepoint.
// Each codepoint gives zero to three results: a finding for a tag character, a run record
// when a run of tags closes, and the totals at the end of the text.
// The first result of a codepoint passes through the input register and the output register.
// Throughput: one codepoint per cycle while each gives at most one result and m_tready is high;
// one with more results holds the input register while the single output register takes each.
// Reset clears the run state, the counters and both valid flags; no beat is pending after it.
// The end of a text clears all state as well.
// When m_tready is low the output register holds its beat; the input register then fills
// and s_tready drops until the receiver takes the result.
module unicode_tag_run_detector
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // code_point[20:0], byte_offset[52:21], zero fill
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // tag_code, where_at, mirrored_ascii, run_length, is_flag,
                                    // total_tags, total_flag, total_hidden, zero fill
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast
);

    logic               in_valid_reg, in_valid_next;
    tagrd_pkg::item_t   item_reg;
    logic               consume;
    logic               accept;
    tagrd_pkg::result_t results [tagrd_pkg::RES_SLOTS];
    logic [2:0]         present;
    tagrd_pkg::result_t m_result;

    assign s_tready      = !in_valid_reg || consume;
    assign accept        = s_tvalid && s_tready;
    assign in_valid_next = accept || (in_valid_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.code_point    <= s_tdata[20:0];
            item_reg.byte_offset   <= s_tdata[52:21];
            item_reg.end_of_stream <= s_tlast;
        end
    end

    tagrd_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_reg),
        .consume (consume),
        .results (results),
        .present (present)
    );

    tagrd_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .results    (results),
        .present    (present),
        .consume    (consume),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (m_result),
        .m_last     (m_tlast)
    );

    assign m_tuser = m_result.kind;
    assign m_tdata = {3'b000,
                      m_result.total_hidden,
                      m_result.total_flag,
                      m_result.total_tags,
                      m_result.is_flag,
                      m_result.run_length,
                      m_result.mirrored_ascii,
                      m_result.where_at,
                      m_result.tag_code};

endmodule
